// ----- design/rpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpc_pkg
// Types and constants shared by the response packet checker.
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned NIBBLE_W   = 4;
    localparam int unsigned POS_W      = 7;

    // Header bytes must carry both ok bits
    localparam logic [BYTE_W-1:0] HDR_OK_MASK = 8'hC0;

    // Packet layout
    localparam logic [POS_W-1:0] POS_HDR0     = 7'd0;
    localparam logic [POS_W-1:0] POS_HDR1     = 7'd1;
    localparam logic [POS_W-1:0] POS_COUNT    = 7'd2;
    localparam logic [POS_W-1:0] POS_MIN_CHK  = 7'd3;

    // Length = cmds * CMD_BYTES + polls * POLL_BYTES + FIXED_BYTES
    localparam logic [POS_W-1:0] CMD_BYTES    = 7'd3;
    localparam logic [POS_W-1:0] POLL_BYTES   = 7'd2;
    localparam logic [POS_W-1:0] FIXED_BYTES  = 7'd4;

    typedef struct packed {
        logic [NIBBLE_W-1:0] sum_high;
        logic [NIBBLE_W-1:0] sum_low;
    } fletcher_t;

    // Listed from the top bit down; header_ok sits in bit 0
    typedef struct packed {
        logic [3:0]          pad;
        logic                checksum_ok;
        logic [BYTE_W-1:0]   computed_sum;
        logic [POS_W-1:0]    packet_length;
        logic [NIBBLE_W-1:0] poll_count;
        logic [NIBBLE_W-1:0] cmd_count;
        logic [2:0]          seq_index;
        logic                header_ok;
    } result_t;

endpackage

// ----- design/response_packet_checker_unit.sv -----
// ----------------------------------------------------------------------------
// response_packet_checker_unit
// Checks header, length and nibble Fletcher sum of response packets.
// ----------------------------------------------------------------------------
// Result path: the accepted checksum byte passes the input register, then the result register.
// Throughput: one byte per cycle; the input register and the result register
//   advance together, and only a held result stalls the checksum byte.
// Reset: synchronous active-low aresetn clears packet state and both valids.
module response_packet_checker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] header_ok, [3:1] seq_index, [7:4] cmd_count,
                                   // [11:8] poll_count, [18:12] packet_length,
                                   // [26:19] computed_sum, [27] checksum_ok
);

    localparam int unsigned BW = rpc_pkg::BYTE_W;
    localparam int unsigned PW = rpc_pkg::POS_W;

    // Input register
    logic          in_valid_reg;
    logic [BW-1:0] in_byte_reg;
    logic          in_start_reg;

    // Packet state
    logic                in_packet_reg,    in_packet_next;
    logic [PW-1:0]       byte_pos_reg,     byte_pos_next;
    logic [BW-1:0]       first_header_reg, first_header_next;
    logic                header_match_reg, header_match_next;
    logic [BW-1:0]       count_byte_reg,   count_byte_next;
    logic [PW-1:0]       exp_len_reg,      exp_len_next;
    rpc_pkg::fletcher_t  sums_reg,         sums_next;

    // Result register
    logic                m_valid_reg;
    rpc_pkg::result_t    result_reg,       result_next;

    logic                active;
    logic                is_check;
    logic                advance;
    logic [PW-1:0]       pos_eff;
    logic                match_eff;
    logic [BW-1:0]       count_eff;
    logic [PW-1:0]       len_eff;
    rpc_pkg::fletcher_t  sums_eff;
    rpc_pkg::fletcher_t  sums_add;
    logic [PW-1:0]       len_calc;
    logic [BW-1:0]       sum_byte;

    rpc_fletcher u_fletcher (
        .data_byte (in_byte_reg),
        .sums_in   (sums_eff),
        .sums_out  (sums_add)
    );

    always_comb begin
        // A start word opens a fresh packet and drops the partial one
        active    = in_valid_reg && (in_start_reg || in_packet_reg);
        pos_eff   = in_start_reg ? '0 : byte_pos_reg;
        match_eff = in_start_reg ? 1'b0 : header_match_reg;
        count_eff = in_start_reg ? '0 : count_byte_reg;
        len_eff   = in_start_reg ? '0 : exp_len_reg;
        sums_eff  = in_start_reg ? '0 : sums_reg;

        is_check  = active && (pos_eff >= rpc_pkg::POS_MIN_CHK)
                    && (({1'b0, pos_eff} + 8'd1) >= {1'b0, len_eff});
        advance   = in_valid_reg && (!is_check || !m_valid_reg || m_tready);

        len_calc  = {3'b000, in_byte_reg[7:4]} * rpc_pkg::CMD_BYTES
                  + {3'b000, in_byte_reg[3:0]} * rpc_pkg::POLL_BYTES
                  + rpc_pkg::FIXED_BYTES;
        sum_byte  = {sums_eff.sum_high, sums_eff.sum_low};

        in_packet_next    = in_packet_reg;
        byte_pos_next     = byte_pos_reg;
        first_header_next = first_header_reg;
        header_match_next = header_match_reg;
        count_byte_next   = count_byte_reg;
        exp_len_next      = exp_len_reg;
        sums_next         = sums_reg;

        if (advance && active) begin
            header_match_next = match_eff;
            count_byte_next   = count_eff;
            exp_len_next      = len_eff;
            sums_next         = sums_eff;
            if (is_check) begin
                in_packet_next = 1'b0;
                byte_pos_next  = '0;
            end else begin
                in_packet_next = 1'b1;
                byte_pos_next  = pos_eff + 7'd1;
                sums_next      = sums_add;
                case (pos_eff)
                    rpc_pkg::POS_HDR0: begin
                        first_header_next = in_byte_reg;
                    end
                    rpc_pkg::POS_HDR1: begin
                        header_match_next = (in_byte_reg == first_header_reg);
                    end
                    rpc_pkg::POS_COUNT: begin
                        count_byte_next = in_byte_reg;
                        exp_len_next    = len_calc;
                    end
                    default: begin
                    end
                endcase
            end
        end

        result_next.pad           = '0;
        result_next.header_ok     = match_eff
                                    && ((first_header_reg & rpc_pkg::HDR_OK_MASK)
                                        == rpc_pkg::HDR_OK_MASK);
        result_next.seq_index     = first_header_reg[2:0];
        result_next.cmd_count     = count_eff[7:4];
        result_next.poll_count    = count_eff[3:0];
        result_next.packet_length = len_eff;
        result_next.computed_sum  = sum_byte;
        result_next.checksum_ok   = (in_byte_reg == sum_byte);
    end

    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            in_packet_reg    <= 1'b0;
            byte_pos_reg     <= '0;
            first_header_reg <= '0;
            header_match_reg <= 1'b0;
            count_byte_reg   <= '0;
            exp_len_reg      <= '0;
            sums_reg         <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            // Hold the result until taken
            if (advance && is_check) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            in_packet_reg    <= in_packet_next;
            byte_pos_reg     <= byte_pos_next;
            first_header_reg <= first_header_next;
            header_match_reg <= header_match_next;
            count_byte_reg   <= count_byte_next;
            exp_len_reg      <= exp_len_next;
            sums_reg         <= sums_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (advance && is_check) begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- design/rpc_fletcher.sv -----
// ----------------------------------------------------------------------------
// rpc_fletcher
// Folds one byte into the nibble Fletcher sums, high nibble first, mod 16.
// ----------------------------------------------------------------------------
module rpc_fletcher (
    input  logic [rpc_pkg::BYTE_W-1:0] data_byte,
    input  rpc_pkg::fletcher_t         sums_in,
    output rpc_pkg::fletcher_t         sums_out
);

    logic [rpc_pkg::NIBBLE_W-1:0] low_a;
    logic [rpc_pkg::NIBBLE_W-1:0] high_a;

    // Nibble-wide adds wrap mod 16 on their own
    always_comb begin
        low_a             = sums_in.sum_low + data_byte[7:4];
        high_a            = sums_in.sum_high + low_a;
        sums_out.sum_low  = low_a + data_byte[3:0];
        sums_out.sum_high = high_a + sums_out.sum_low;
    end

endmodule

// ----- design/rpc_checker.sv -----
// ----------------------------------------------------------------------------
// rpc_checker
// Port-level assertions for the response packet checker, bound to the top.
// ----------------------------------------------------------------------------
module rpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic [6:0] len_expect;

    assign len_expect = {3'b000, m_tdata[7:4]} * 7'd3
                      + {3'b000, m_tdata[11:8]} * 7'd2 + 7'd4;

    // Stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("valid or stall left after reset");

    // An empty result slot never blocks the input
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with result slot empty");

    a_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:12] == len_expect) && (m_tdata[31:28] == 4'd0))
        else $error("packet length does not follow counts");

    a_sum_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid, 2) || $past(s_tvalid, 3)
                            || !$past(s_tready, 2) || $past(m_tvalid))
        else $error("result word without an input word");

endmodule

bind response_packet_checker_unit rpc_checker u_rpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/response_packet_checker_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// response_packet_checker_unit_test
// Streams response bytes into the packet checker and predicts one result
// word per completed packet: header check, sequence index, counts, length,
// nibble Fletcher sum and checksum flag. Directed framing and header cases
// come first, then random packets, some broken, corrupted or restarted.
// ----------------------------------------------------------------------------
module response_packet_checker_unit_test;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] start_req
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [0] header_ok, [3:1] seq_index, [7:4] cmd_count,
                            // [11:8] poll_count, [18:12] packet_length,
                            // [26:19] computed_sum, [27] checksum_ok

    // Predicted packet state
    bit                          pkt_open;
    logic [rpc_pkg::POS_W-1:0]   pkt_pos;
    logic [rpc_pkg::BYTE_W-1:0]  hdr_first;
    bit                          hdr_equal;
    logic [rpc_pkg::BYTE_W-1:0]  count_field;
    logic [rpc_pkg::POS_W-1:0]   pkt_len;
    rpc_pkg::fletcher_t          run_sum;

    rpc_pkg::result_t   pending_results[$];
    bit                 steady_flow;
    int unsigned        bytes_counted;
    int unsigned        mismatches;
    int unsigned        results_seen;
    int unsigned        sums_ok_seen;
    int unsigned        headers_ok_seen;

    response_packet_checker_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // High nibble first, then low nibble; both sums wrap at 16
    function automatic rpc_pkg::fletcher_t fletcher_add(rpc_pkg::fletcher_t s,
                                                       logic [7:0] b);
        s.sum_low  = s.sum_low + b[7:4];
        s.sum_high = s.sum_high + s.sum_low;
        s.sum_low  = s.sum_low + b[3:0];
        s.sum_high = s.sum_high + s.sum_low;
        return s;
    endfunction

    // Advance the packet state by one accepted word; returns 0 for an ignored word
    function automatic bit predict_byte(logic [7:0] b, logic start);
        rpc_pkg::result_t r;
        if (start) begin
            pkt_open    = 1'b1;
            pkt_pos     = rpc_pkg::POS_HDR0;
            run_sum     = '0;
            hdr_equal   = 1'b0;
            count_field = '0;
            pkt_len     = '0;
        end else if (!pkt_open) begin
            return 1'b0;
        end
        if (pkt_pos >= rpc_pkg::POS_MIN_CHK && int'(pkt_pos) + 1 >= int'(pkt_len)) begin
            r               = '0;
            r.header_ok     = hdr_equal
                              && ((hdr_first & rpc_pkg::HDR_OK_MASK) == rpc_pkg::HDR_OK_MASK);
            r.seq_index     = hdr_first[2:0];
            r.cmd_count     = count_field[7:4];
            r.poll_count    = count_field[3:0];
            r.packet_length = pkt_len;
            r.computed_sum  = run_sum;
            r.checksum_ok   = (b == run_sum);
            pending_results = {pending_results, r};
            pkt_open = 1'b0;
            pkt_pos  = rpc_pkg::POS_HDR0;
            return 1'b1;
        end
        case (pkt_pos)
            rpc_pkg::POS_HDR0: hdr_first = b;
            rpc_pkg::POS_HDR1: hdr_equal = (b == hdr_first);
            rpc_pkg::POS_COUNT: begin
                count_field = b;
                pkt_len     = b[7:4] * rpc_pkg::CMD_BYTES + b[3:0] * rpc_pkg::POLL_BYTES
                              + rpc_pkg::FIXED_BYTES;
            end
            default: ;
        endcase
        run_sum = fletcher_add(run_sum, b);
        pkt_pos = pkt_pos + 1'b1;
        return 1'b1;
    endfunction

    // Called at a falling edge; returns at the falling edge after the handshake
    task automatic send_byte(input logic [7:0] b, input logic start);
        while (!steady_flow && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        if (predict_byte(b, start))
            bytes_counted++;
        @(negedge aclk);
    endtask

    // Send up to cut_at words of a packet; the checksum is flipped when corrupt
    task automatic send_packet(input logic [7:0] hdr0, input logic [7:0] hdr1,
                               input logic [7:0] counts, input bit corrupt,
                               input int cut_at);
        rpc_pkg::fletcher_t acc;
        int                 len;
        logic [7:0]         b;
        acc = '0;
        len = counts[7:4] * 3 + counts[3:0] * 2 + 4;
        for (int i = 0; i < len && i < cut_at; i++) begin
            if (i == 0)            b = hdr0;
            else if (i == 1)       b = hdr1;
            else if (i == 2)       b = counts;
            else if (i == len - 1) b = corrupt ? (acc ^ 8'($urandom_range(1, 255))) : acc;
            else                   b = 8'($urandom_range(255));
            acc = fletcher_add(acc, b);
            send_byte(b, i == 0);
        end
    endtask

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
    endtask

    always @(negedge aclk)
        m_tready <= steady_flow || ($urandom_range(99) >= 23);

    always @(posedge aclk) begin
        rpc_pkg::result_t got;
        rpc_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", 0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.header_ok != want.header_ok)
                    note_mismatch("header_ok", 32'(want.header_ok), 32'(got.header_ok));
                if (got.seq_index != want.seq_index)
                    note_mismatch("seq_index", 32'(want.seq_index), 32'(got.seq_index));
                if (got.cmd_count != want.cmd_count)
                    note_mismatch("cmd_count", 32'(want.cmd_count), 32'(got.cmd_count));
                if (got.poll_count != want.poll_count)
                    note_mismatch("poll_count", 32'(want.poll_count), 32'(got.poll_count));
                if (got.packet_length != want.packet_length)
                    note_mismatch("packet_length", 32'(want.packet_length),
                                  32'(got.packet_length));
                if (got.computed_sum != want.computed_sum)
                    note_mismatch("computed_sum", 32'(want.computed_sum),
                                  32'(got.computed_sum));
                if (got.checksum_ok != want.checksum_ok)
                    note_mismatch("checksum_ok", 32'(want.checksum_ok), 32'(got.checksum_ok));
                if (want.checksum_ok) sums_ok_seen++;
                if (want.header_ok)   headers_ok_seen++;
            end
        end
    end

    task automatic test_good_packets;
        send_packet(8'hC7, 8'hC7, 8'h00, 1'b0, 99);
        send_packet(8'hF8, 8'hF8, 8'h10, 1'b0, 99);
    endtask

    task automatic test_bad_packets;
        send_packet(8'hFF, 8'hFF, 8'h00, 1'b1, 99);
        // header bytes differ
        send_packet(8'hC1, 8'hC2, 8'h01, 1'b0, 99);
        // ok bits missing
        send_packet(8'h3F, 8'h3F, 8'h00, 1'b0, 99);
    endtask

    task automatic test_framing;
        // ignored outside a packet
        send_byte(8'hFF, 1'b0);
        // restart drops the partial packet
        send_packet(8'hC5, 8'hC5, 8'h00, 1'b0, 2);
        send_packet(8'hC2, 8'hC2, 8'h00, 1'b0, 99);
    endtask

    task automatic test_random_traffic(input int unsigned n_bytes);
        logic [7:0]  hdr0;
        logic [7:0]  hdr1;
        logic [7:0]  counts;
        int unsigned pick;
        int          len;
        int          cut;
        int unsigned stop_at;
        stop_at = bytes_counted + n_bytes;
        while (bytes_counted < stop_at) begin
            if ($urandom_range(99) < 10)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
            hdr0 = 8'($urandom_range(255));
            if ($urandom_range(99) < 85) hdr0[7:6] = 2'b11;
            hdr1 = ($urandom_range(99) < 85) ? hdr0 : 8'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 85)      counts = {2'b00, 2'($urandom_range(3)), 2'b00, 2'($urandom_range(3))};
            else if (pick < 97) counts = 8'($urandom_range(255));
            else                counts = 8'hFF;
            len = counts[7:4] * 3 + counts[3:0] * 2 + 4;
            cut = ($urandom_range(99) < 10) ? $urandom_range(1, len - 1) : len;
            send_packet(hdr0, hdr1, counts, $urandom_range(99) < 15, cut);
        end
    endtask

    task automatic test_back_to_back(input int unsigned n_bytes);
        steady_flow = 1'b1;
        test_random_traffic(n_bytes);
        steady_flow = 1'b0;
    endtask

    initial begin
        int unsigned waited;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        steady_flow   = 1'b0;
        pkt_open      = 1'b0;
        pkt_pos       = '0;
        hdr_first     = '0;
        hdr_equal     = 1'b0;
        count_field   = '0;
        pkt_len       = '0;
        run_sum       = '0;
        bytes_counted = 0;
        mismatches    = 0;
        results_seen  = 0;
        sums_ok_seen  = 0;
        headers_ok_seen = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_good_packets();
        test_bad_packets();
        test_framing();
        test_random_traffic(500);
        test_back_to_back(300);
        test_random_traffic(350);
        s_tvalid <= 1'b0;

        // drain: hold until every predicted word is back, with a bound
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0)
            note_mismatch("missing results", 0, pending_results.size());

        $display("Sent %0d packet bytes, checked %0d result words", bytes_counted,
                 results_seen);
        $display("Of those, %0d had a good header and %0d a good checksum",
                 headers_ok_seen, sums_ok_seen);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
